@@ hdl/pf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prime factorizer package
// Sequencer state encoding and fixed constants shared by the factorizer.
// ----------------------------------------------------------------------------
package pf_pkg;

    // First prime, divided out on its own before the odd divisors.
    localparam int unsigned FIRST_PRIME = 2;
    // First odd trial divisor.
    localparam int unsigned FIRST_ODD   = 3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_CHECK = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

endpackage : pf_pkg
`default_nettype wire

@@ hdl/prime_factorizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prime factorizer core
// Trial-division factorization of one unsigned value into ascending primes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis_*) takes one value per transaction. Master channel
//   (m_axis_*) returns its prime factors in ascending order, one transaction
//   per multiplicity; tlast marks the final factor of a value. A value of 0
//   or 1 has no factors and returns one transaction with tuser set, tdata 0
//   and tlast set.
//   Only the low WIDTH bits of the input value take part.
// Timing:
//   One shared restoring divider does all the work, followed by an
//   inspection of quotient and remainder after each division. Each factor
//   found and each new trial divisor costs one division. s_axis_tready is
//   high only while idle; the block accepts the next value after the
//   transaction that carries tlast.
// Reset and stalls:
//   rst_n clears the sequencer to idle with no result pending. While the
//   receiver holds m_axis_tready low, the result holds in the output register
//   and the sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module prime_factorizer_core
    import pf_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] factor
    output logic             m_axis_tlast,   // last
    output logic             m_axis_tuser    // none
);

    // Trial divisors never go much above sqrt(2^WIDTH), so DW bits hold them.
    localparam int DW = WIDTH / 2 + 1;
    localparam int CW = $clog2(WIDTH);

    state_t            state_reg,  state_next;
    logic [WIDTH-1:0]  rem_reg,    rem_next;    // value still to factor
    logic [DW-1:0]     d_reg,      d_next;      // current trial divisor
    logic [WIDTH-1:0]  work_reg,   work_next;   // dividend in, quotient out
    logic [DW-1:0]     part_reg,   part_next;   // partial remainder
    logic [CW-1:0]     cnt_reg,    cnt_next;    // division steps left
    logic              inner_reg,  inner_next;  // repeat division by same divisor
    logic [WIDTH-1:0]  fac_reg,    fac_next;
    logic              last_reg,   last_next;
    logic              none_reg,   none_next;

    // Input and output width adaptation.
    logic [WIDTH+31:0] in_ext;
    logic [WIDTH-1:0]  in_value;
    logic [WIDTH+31:0] fac_ext;

    // Divider step.
    logic [DW:0]       trial;
    logic [DW:0]       diff;
    logic              fits;

    // Inspection of a finished division.
    logic [WIDTH-1:0]  d_ext;
    logic              d_is_two;
    logic              q_is_one;
    logic              bound_fail;

    assign in_ext   = {{WIDTH{1'b0}}, s_axis_tdata};
    assign in_value = in_ext[WIDTH-1:0];
    assign fac_ext  = {32'b0, fac_reg};

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_EMIT);
    assign m_axis_tdata  = fac_ext[31:0];
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = none_reg;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    assign trial = {part_reg, work_reg[WIDTH-1]};
    assign fits  = (trial >= {1'b0, d_reg});
    assign diff  = trial - {1'b0, d_reg};

    assign d_ext    = {{(WIDTH-DW){1'b0}}, d_reg};
    assign d_is_two = (d_reg == DW'(FIRST_PRIME));
    assign q_is_one = (work_reg == WIDTH'(1));
    // Odd divisor loop ends once divisor exceeds remaining / divisor.
    assign bound_fail = !d_is_two && !inner_reg && (d_ext > work_reg);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        d_next     = d_reg;
        work_next  = work_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        inner_next = inner_reg;
        fac_next   = fac_reg;
        last_next  = last_reg;
        none_next  = none_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_value < WIDTH'(FIRST_PRIME))
                    begin
                        fac_next   = '0;
                        last_next  = 1'b1;
                        none_next  = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        rem_next   = in_value;
                        d_next     = DW'(FIRST_PRIME);
                        inner_next = 1'b1;
                        work_next  = in_value;
                        part_next  = '0;
                        cnt_next   = CW'(WIDTH - 1);
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                part_next = fits ? diff[DW-1:0] : trial[DW-1:0];
                work_next = {work_reg[WIDTH-2:0], fits};
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                none_next = 1'b0;
                if (bound_fail)
                begin
                    // Whatever is left is prime (always odd and above 2 here).
                    fac_next   = rem_reg;
                    last_next  = 1'b1;
                    state_next = S_EMIT;
                end
                else if (part_reg == '0)
                begin
                    // Divisor goes in: report it, keep the quotient.
                    fac_next   = d_ext;
                    last_next  = q_is_one;
                    rem_next   = work_reg;
                    inner_next = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    // Advance to the next odd divisor and divide again.
                    d_next     = d_is_two ? DW'(FIRST_ODD) : d_reg + DW'(2);
                    inner_next = 1'b0;
                    work_next  = rem_reg;
                    part_next  = '0;
                    cnt_next   = CW'(WIDTH - 1);
                    state_next = S_DIV;
                end
            end

            S_EMIT:
            begin
                if (m_axis_tready)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Try the same divisor on the new remaining value.
                        work_next  = rem_reg;
                        part_next  = '0;
                        cnt_next   = CW'(WIDTH - 1);
                        state_next = S_DIV;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rem_reg   <= '0;
            d_reg     <= '0;
            inner_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            d_reg     <= d_next;
            inner_reg <= inner_next;
        end
    end

    // Datapath and output payload, no reset needed.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        part_reg <= part_next;
        cnt_reg  <= cnt_next;
        fac_reg  <= fac_next;
        last_reg <= last_next;
        none_reg <= none_next;
    end

`ifndef ASSERT_OFF
    // Input and output never open together: one value in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // A no-factor result is a lone zero that closes the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 32'd0))
        else $error("no-factor result malformed");

    // A real factor is at least two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (fac_reg >= WIDTH'(FIRST_PRIME)))
        else $error("factor below two");

    // Trial divisor is two or odd while dividing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (d_is_two || d_reg[0]))
        else $error("even trial divisor above two");

    // Inspection follows only a finished division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_DIV && $past(cnt_reg) == '0))
        else $error("division cut short");
`endif

endmodule : prime_factorizer_core
`default_nettype wire
